FILE: rtl/core/sli_pkg.sv
// Shared constants, widths and cell control type for the sorted list table.
`default_nettype none
package sli_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned POS_W        = 10;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned ECNT_W       = 7;
  localparam int unsigned IN_DATA_W    = 48;
  localparam int unsigned OUT_DATA_W   = 48;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef struct packed {
    logic                    cmp_en;
    logic signed [VAL_W-1:0] cmp_value;
    logic [POS_W-1:0]        cmp_idx;
    logic                    ins_en;
    logic                    rem_en;
    logic signed [VAL_W-1:0] ins_value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/sli_cell.sv
// One storage cell of the sorted list: compares, holds a value and shifts with its neighbors.
`default_nettype none
module sli_cell #(
  parameter int unsigned INDEX = 0
) (
  input  wire logic                           clk,
  input  wire sli_pkg::cell_ctrl_t            ctrl,
  input  wire logic                           valid_i,
  input  wire logic signed [sli_pkg::VAL_W-1:0] left_value,
  input  wire logic                           left_lt,
  input  wire logic signed [sli_pkg::VAL_W-1:0] right_value,
  output logic signed [sli_pkg::VAL_W-1:0]    value_o,
  output logic                                lt_o,
  output logic                                eq_o,
  output logic signed [sli_pkg::VAL_W-1:0]    rd_o
);

  logic signed [sli_pkg::VAL_W-1:0] value_r;
  logic                             lt_r;
  logic                             eq_r;
  logic                             hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt_r  <= valid_i && (value_r < ctrl.cmp_value);
      eq_r  <= valid_i && (value_r == ctrl.cmp_value);
      hit_r <= (ctrl.cmp_idx == sli_pkg::POS_W'(INDEX));
    end
    if (ctrl.ins_en && !lt_r) begin
      value_r <= left_lt ? ctrl.ins_value : left_value;
    end else if (ctrl.rem_en && !lt_r) begin
      value_r <= right_value;
    end
  end

  assign value_o = value_r;
  assign lt_o    = lt_r;
  assign eq_o    = eq_r;
  assign rd_o    = hit_r ? value_r : '0;

endmodule
`default_nettype wire

FILE: rtl/core/sorted_list_table.sv
// Sorted list table: a row of compare-and-shift cells holding signed values in ascending order.
// For each request, in the transfer cycle every cell compares its value with the request in
// parallel; then in S_APPLY, once the output register is free, all cells shift at once (right
// on insert, left on remove) while the result is written to the output register. A new request
// is accepted as soon as the previous one has reached the output register, so the table takes
// no new request while one waits in S_APPLY. Insert goes ahead of equal values, remove drops
// the first equal value, read takes a 1-based position where 0 acts as 1.
`default_nettype none
module sorted_list_table #(
  parameter int unsigned CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // operation[1:0], value[33:2], position[43:34], zero fill above
  input  wire logic [sli_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // success[0], read_value[32:1], entry_count[39:33], is_empty[40], zero fill above
  output logic [sli_pkg::OUT_DATA_W-1:0]        out_tdata
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t                              state_r;
  logic [CNT_W-1:0]                    count_r;
  logic [sli_pkg::OP_W-1:0]            op_r;
  logic signed [sli_pkg::VAL_W-1:0]    value_r;
  logic [sli_pkg::POS_W-1:0]           idx_r;
  logic                                out_valid_r;
  logic [sli_pkg::OUT_DATA_W-1:0]      out_data_r;

  logic [sli_pkg::OP_W-1:0]            in_op;
  logic signed [sli_pkg::VAL_W-1:0]    in_value;
  logic [sli_pkg::POS_W-1:0]           in_pos;
  logic [sli_pkg::POS_W-1:0]           in_idx;
  logic                                in_fire;
  logic                                apply_fire;
  logic                                full;
  logic                                found;
  logic                                rd_ok;
  logic                                ok;
  logic signed [sli_pkg::VAL_W-1:0]    rd_value;
  logic signed [sli_pkg::VAL_W-1:0]    rd_or;
  logic [CNT_W-1:0]                    count_nxt;
  sli_pkg::cell_ctrl_t                 ctrl;

  logic signed [sli_pkg::VAL_W-1:0]    cell_value [CAPACITY];
  logic signed [sli_pkg::VAL_W-1:0]    cell_rd    [CAPACITY];
  logic [CAPACITY-1:0]                 cell_lt;
  logic [CAPACITY-1:0]                 cell_eq;
  logic [CAPACITY-1:0]                 cell_valid;

  assign in_op    = in_tdata[1:0];
  assign in_value = in_tdata[33:2];
  assign in_pos   = in_tdata[43:34];
  assign in_idx   = (in_pos == '0) ? '0 : in_pos - 1'b1;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign apply_fire = (state_r == S_APPLY) && (!out_valid_r || out_tready);

  assign full  = (count_r >= CNT_W'(CAPACITY));
  assign found = |cell_eq;
  assign rd_ok = (idx_r < sli_pkg::POS_W'(count_r));

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    ok        = 1'b0;
    rd_value  = '0;
    count_nxt = count_r;
    case (op_r)
      sli_pkg::OP_INSERT: begin
        ok = !full;
        if (!full) begin
          count_nxt = count_r + 1'b1;
        end
      end
      sli_pkg::OP_REMOVE: begin
        ok = found;
        if (found) begin
          count_nxt = count_r - 1'b1;
        end
      end
      sli_pkg::OP_READ: begin
        ok = rd_ok;
        if (rd_ok) begin
          rd_value = rd_or;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctrl.cmp_en    = in_fire;
    ctrl.cmp_value = in_value;
    ctrl.cmp_idx   = in_idx;
    ctrl.ins_en    = apply_fire && (op_r == sli_pkg::OP_INSERT) && !full;
    ctrl.rem_en    = apply_fire && (op_r == sli_pkg::OP_REMOVE) && found;
    ctrl.ins_value = value_r;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sli_pkg::VAL_W-1:0] left_value;
    logic                             left_lt;
    logic signed [sli_pkg::VAL_W-1:0] right_value;

    assign cell_valid[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_value = value_r;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_lt    = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    sli_cell #(
      .INDEX(i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid_i    (cell_valid[i]),
      .left_value (left_value),
      .left_lt    (left_lt),
      .right_value(right_value),
      .value_o    (cell_value[i]),
      .lt_o       (cell_lt[i]),
      .eq_o       (cell_eq[i]),
      .rd_o       (cell_rd[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (apply_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_fire) begin
            state_r    <= S_IDLE;
            count_r    <= count_nxt;
            out_data_r <= {7'd0, (count_nxt == '0), sli_pkg::ECNT_W'(count_nxt), rd_value, ok};
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_op;
      value_r <= in_value;
      idx_r   <= in_idx;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_count_at_apply : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(state_r == S_APPLY))
    else $error("stored count changed outside the apply cycle");

  a_fail_reads_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r[0]) |-> (out_data_r[32:1] == '0))
    else $error("failed request carries a nonzero read value");

  a_no_accept_in_apply : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY && !apply_fire) |=> (state_r == S_APPLY))
    else $error("apply cycle left without writing the result");

endmodule
`default_nettype wire
